// ----- hdl/tmbp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the TFTP message byte parser.
package tmbp_pkg;

  localparam int LEN_W = 17;
  localparam logic [LEN_W-1:0] LEN_MAX = 17'h1ffff;

  // field kinds
  localparam logic [3:0] KIND_OPCODE  = 4'd0;
  localparam logic [3:0] KIND_NAME    = 4'd1;
  localparam logic [3:0] KIND_SIZE    = 4'd2;
  localparam logic [3:0] KIND_BLOCK   = 4'd3;
  localparam logic [3:0] KIND_DATA    = 4'd4;
  localparam logic [3:0] KIND_ERRCODE = 4'd5;
  localparam logic [3:0] KIND_ERRTEXT = 4'd6;
  localparam logic [3:0] KIND_USER    = 4'd7;
  localparam logic [3:0] KIND_FLAG    = 4'd8;
  localparam logic [3:0] KIND_NONE    = 4'd9;

  // opcodes
  localparam logic [15:0] OP_RRQ     = 16'd1;
  localparam logic [15:0] OP_WRQ     = 16'd2;
  localparam logic [15:0] OP_DATA    = 16'd3;
  localparam logic [15:0] OP_ACK     = 16'd4;
  localparam logic [15:0] OP_ERROR   = 16'd5;
  localparam logic [15:0] OP_END_A   = 16'd6;
  localparam logic [15:0] OP_USER    = 16'd7;
  localparam logic [15:0] OP_NAMED   = 16'd8;
  localparam logic [15:0] OP_FLAGGED = 16'd9;
  localparam logic [15:0] OP_END_B   = 16'd10;

  // field index codes
  localparam logic [1:0] FI_OPCODE = 2'd0;
  localparam logic [1:0] FI_FIRST  = 2'd1;
  localparam logic [1:0] FI_SECOND = 2'd2;
  localparam logic [1:0] FI_DATA   = 2'd3;

  typedef struct packed {
    logic [1:0]       field_index;
    logic [15:0]      opcode;
    logic [7:0]       high_byte;
    logic             half_word;
    logic [15:0]      packet_size;
    logic [15:0]      data_count;
    logic [LEN_W-1:0] length_count;
  } parse_state_t;

  typedef struct packed {
    logic [15:0]      msg_type;
    logic [3:0]       field_kind;
    logic [7:0]       field_byte;
    logic             byte_valid;
    logic [15:0]      word_value;
    logic             word_valid;
    logic             message_done;
    logic [LEN_W-1:0] message_length;
    logic             bad_opcode;
  } result_t;

endpackage

// ----- hdl/tftp_message_byte_parser_unit.sv -----
`timescale 1ns / 1ps
// Top level of the TFTP message byte parser.
// An accepted byte request passes through the input register, then the result register,
// before its result is valid.
// Throughput: one byte per cycle while the result is not stalled by out_ready.
// A stalled result holds a full input register; in_ready then follows out_ready.
// Synchronous reset clears parser state and both valid flags.
module tftp_message_byte_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] msg_type,
  output logic [3:0]  field_kind,
  output logic [7:0]  field_byte,
  output logic        byte_valid,
  output logic [15:0] word_value,
  output logic        word_valid,
  output logic        message_done,
  output logic [16:0] message_length,
  output logic        bad_opcode
);

  logic              take;
  logic              held_valid;
  logic [7:0]        held_byte;
  logic              fire;
  tmbp_pkg::result_t res;
  tmbp_pkg::result_t res_q;

  assign take = !out_valid || out_ready;
  assign fire = held_valid && take;

  tmbp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  tmbp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (held_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign msg_type       = res_q.msg_type;
  assign field_kind     = res_q.field_kind;
  assign field_byte     = res_q.field_byte;
  assign byte_valid     = res_q.byte_valid;
  assign word_value     = res_q.word_value;
  assign word_valid     = res_q.word_valid;
  assign message_done   = res_q.message_done;
  assign message_length = res_q.message_length;
  assign bad_opcode     = res_q.bad_opcode;

endmodule

// ----- hdl/tmbp_in_stage.sv -----
`timescale 1ns / 1ps
// Input register stage holding one received byte request.
module tmbp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ----- hdl/tmbp_core.sv -----
`timescale 1ns / 1ps
// Parser state and the per-byte field decode.
module tmbp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          byte_in,
  output tmbp_pkg::result_t   res
);

  tmbp_pkg::parse_state_t st, st_next;
  logic        take_pair;
  logic        pair_done;
  logic [15:0] pair_word;
  logic [15:0] count_inc;
  logic        done;
  logic        bad;

  assign pair_done = st.half_word;
  assign pair_word = {st.high_byte, byte_in};
  assign count_inc = st.data_count + 16'd1;

  always_comb begin
    st_next   = st;
    res       = '0;
    take_pair = 1'b0;
    done      = 1'b0;
    bad       = 1'b0;
    res.field_kind = tmbp_pkg::KIND_NONE;

    st_next.length_count = (st.length_count != tmbp_pkg::LEN_MAX) ?
                           st.length_count + 17'd1 : tmbp_pkg::LEN_MAX;
    res.message_length = st_next.length_count;

    if (st.field_index == tmbp_pkg::FI_OPCODE) begin
      res.field_kind = tmbp_pkg::KIND_OPCODE;
      take_pair = 1'b1;
      if (pair_done) begin
        st_next.opcode = pair_word;
        res.word_value = pair_word;
        res.word_valid = 1'b1;
        if (pair_word == tmbp_pkg::OP_END_A || pair_word == tmbp_pkg::OP_END_B) begin
          done = 1'b1;
        end else begin
          st_next.field_index = tmbp_pkg::FI_FIRST;
        end
      end
    end else if ((st.opcode == tmbp_pkg::OP_RRQ || st.opcode == tmbp_pkg::OP_WRQ ||
                  st.opcode == tmbp_pkg::OP_NAMED || st.opcode == tmbp_pkg::OP_USER) &&
                 st.field_index == tmbp_pkg::FI_FIRST) begin
      res.field_kind = (st.opcode == tmbp_pkg::OP_USER) ? tmbp_pkg::KIND_USER
                                                        : tmbp_pkg::KIND_NAME;
      if (byte_in != 8'd0) begin
        res.field_byte = byte_in;
        res.byte_valid = 1'b1;
      end else begin
        done = 1'b1;
      end
    end else if (st.opcode == tmbp_pkg::OP_ACK && st.field_index == tmbp_pkg::FI_FIRST) begin
      res.field_kind = tmbp_pkg::KIND_BLOCK;
      take_pair = 1'b1;
      if (pair_done) begin
        res.word_value = pair_word;
        res.word_valid = 1'b1;
        done = 1'b1;
      end
    end else if (st.opcode == tmbp_pkg::OP_ERROR && st.field_index == tmbp_pkg::FI_FIRST) begin
      res.field_kind = tmbp_pkg::KIND_ERRCODE;
      take_pair = 1'b1;
      if (pair_done) begin
        res.word_value = pair_word;
        res.word_valid = 1'b1;
        st_next.field_index = tmbp_pkg::FI_SECOND;
      end
    end else if (st.opcode == tmbp_pkg::OP_ERROR && st.field_index == tmbp_pkg::FI_SECOND) begin
      res.field_kind = tmbp_pkg::KIND_ERRTEXT;
      if (byte_in != 8'd0) begin
        res.field_byte = byte_in;
        res.byte_valid = 1'b1;
      end else begin
        done = 1'b1;
      end
    end else if (st.opcode == tmbp_pkg::OP_FLAGGED &&
                 st.field_index == tmbp_pkg::FI_FIRST) begin
      res.field_kind = tmbp_pkg::KIND_FLAG;
      res.field_byte = byte_in;
      res.byte_valid = 1'b1;
      st_next.field_index = tmbp_pkg::FI_SECOND;
    end else if (st.opcode == tmbp_pkg::OP_FLAGGED &&
                 st.field_index == tmbp_pkg::FI_SECOND) begin
      res.field_kind = tmbp_pkg::KIND_NAME;
      if (byte_in != 8'd0) begin
        res.field_byte = byte_in;
        res.byte_valid = 1'b1;
      end else begin
        done = 1'b1;
      end
    end else if (st.opcode == tmbp_pkg::OP_DATA && st.field_index == tmbp_pkg::FI_FIRST) begin
      res.field_kind = tmbp_pkg::KIND_SIZE;
      take_pair = 1'b1;
      if (pair_done) begin
        st_next.packet_size = pair_word;
        res.word_value = pair_word;
        res.word_valid = 1'b1;
        st_next.field_index = tmbp_pkg::FI_SECOND;
      end
    end else if (st.opcode == tmbp_pkg::OP_DATA && st.field_index == tmbp_pkg::FI_SECOND) begin
      res.field_kind = tmbp_pkg::KIND_BLOCK;
      take_pair = 1'b1;
      if (pair_done) begin
        res.word_value = pair_word;
        res.word_valid = 1'b1;
        if (st.packet_size == 16'd0) begin
          done = 1'b1;
        end else begin
          st_next.field_index = tmbp_pkg::FI_DATA;
        end
      end
    end else if (st.opcode == tmbp_pkg::OP_DATA && st.field_index == tmbp_pkg::FI_DATA) begin
      res.field_kind = tmbp_pkg::KIND_DATA;
      res.field_byte = byte_in;
      res.byte_valid = 1'b1;
      st_next.data_count = count_inc;
      if (count_inc == st.packet_size) begin
        done = 1'b1;
      end
    end else begin
      // unknown opcode: swallow one byte, then resync
      res.field_kind = tmbp_pkg::KIND_NONE;
      bad = 1'b1;
    end

    if (take_pair) begin
      if (!st.half_word) begin
        st_next.high_byte = byte_in;
        st_next.half_word = 1'b1;
      end else begin
        st_next.high_byte = 8'd0;
        st_next.half_word = 1'b0;
      end
    end

    res.msg_type     = st_next.opcode;
    res.message_done = done;
    res.bad_opcode   = bad;

    if (done || bad) begin
      st_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

// ----- hdl/tmbp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the TFTP message byte parser, bound to the top level.
module tmbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] msg_type,
  input logic [3:0]  field_kind,
  input logic [7:0]  field_byte,
  input logic        byte_valid,
  input logic [15:0] word_value,
  input logic        word_valid,
  input logic        message_done,
  input logic [16:0] message_length,
  input logic        bad_opcode
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(field_kind) &&
      $stable(message_length) && $stable(word_value))
    else $error("result request changed while stalled");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid || field_byte == 8'd0) && (word_valid || word_value == 16'd0))
    else $error("payload not zero without its valid");

  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_opcode |-> field_kind == tmbp_pkg::KIND_NONE && !message_done &&
      !byte_valid && !word_valid)
    else $error("bad opcode result malformed");

  a_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_kind == tmbp_pkg::KIND_OPCODE && !word_valid |->
      msg_type == 16'd0 && message_length == 17'd1)
    else $error("first opcode byte not at message start");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind tftp_message_byte_parser_unit tmbp_checker u_tmbp_checker (.*);

// ----- bench/tb_tftp_message_byte_parser_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the TFTP message byte parser: directed and random byte streams.
module tb_tftp_message_byte_parser_unit;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 1450;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] msg_type;
  logic [3:0]  field_kind;
  logic [7:0]  field_byte;
  logic        byte_valid;
  logic [15:0] word_value;
  logic        word_valid;
  logic        message_done;
  logic [16:0] message_length;
  logic        bad_opcode;

  tftp_message_byte_parser_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .msg_type(msg_type), .field_kind(field_kind), .field_byte(field_byte),
    .byte_valid(byte_valid), .word_value(word_value), .word_valid(word_valid),
    .message_done(message_done), .message_length(message_length),
    .bad_opcode(bad_opcode)
  );

  // parser model state
  logic [1:0]                 fidx;
  logic [15:0]                op_reg;
  logic [7:0]                 hi_byte;
  logic                       half;
  logic [15:0]                size_reg;
  logic [15:0]                data_cnt;
  logic [tmbp_pkg::LEN_W-1:0] len_cnt;

  tmbp_pkg::result_t pending_results[$];

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  results_seen = 0;
  int  messages_done = 0;
  int  opcodes_rejected = 0;
  int  longest_length = 0;
  int  stall_cnt = 0;
  int  hold_cycles = 0;
  bit  send_gaps = 1'b1;
  bit  take_gaps = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_parser();
    fidx = tmbp_pkg::FI_OPCODE;
    op_reg = '0;
    hi_byte = '0;
    half = 1'b0;
    size_reg = '0;
    data_cnt = '0;
    len_cnt = '0;
  endfunction

  function automatic bit collect_pair(input logic [7:0] b, output logic [15:0] w);
    w = '0;
    if (!half) begin
      hi_byte = b;
      half = 1'b1;
      return 1'b0;
    end
    w = {hi_byte, b};
    half = 1'b0;
    hi_byte = '0;
    return 1'b1;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, output tmbp_pkg::result_t r);
    logic [15:0] w;
    r = '0;
    r.field_kind = tmbp_pkg::KIND_NONE;
    len_cnt = (len_cnt < tmbp_pkg::LEN_MAX) ? len_cnt + 1'b1 : tmbp_pkg::LEN_MAX;
    r.message_length = len_cnt;
    if (fidx == tmbp_pkg::FI_OPCODE) begin
      r.field_kind = tmbp_pkg::KIND_OPCODE;
      if (collect_pair(b, w)) begin
        op_reg = w;
        r.word_value = w;
        r.word_valid = 1'b1;
        if (w == tmbp_pkg::OP_END_A || w == tmbp_pkg::OP_END_B) r.message_done = 1'b1;
        else fidx = tmbp_pkg::FI_FIRST;
      end
    end else if ((op_reg == tmbp_pkg::OP_RRQ || op_reg == tmbp_pkg::OP_WRQ ||
                  op_reg == tmbp_pkg::OP_NAMED || op_reg == tmbp_pkg::OP_USER) &&
                 fidx == tmbp_pkg::FI_FIRST) begin
      r.field_kind = (op_reg == tmbp_pkg::OP_USER) ? tmbp_pkg::KIND_USER
                                                   : tmbp_pkg::KIND_NAME;
      if (b != 8'h00) begin
        r.field_byte = b;
        r.byte_valid = 1'b1;
      end else r.message_done = 1'b1;
    end else if (op_reg == tmbp_pkg::OP_ACK && fidx == tmbp_pkg::FI_FIRST) begin
      r.field_kind = tmbp_pkg::KIND_BLOCK;
      if (collect_pair(b, w)) begin
        r.word_value = w;
        r.word_valid = 1'b1;
        r.message_done = 1'b1;
      end
    end else if (op_reg == tmbp_pkg::OP_ERROR && fidx == tmbp_pkg::FI_FIRST) begin
      r.field_kind = tmbp_pkg::KIND_ERRCODE;
      if (collect_pair(b, w)) begin
        r.word_value = w;
        r.word_valid = 1'b1;
        fidx = tmbp_pkg::FI_SECOND;
      end
    end else if (op_reg == tmbp_pkg::OP_ERROR && fidx == tmbp_pkg::FI_SECOND) begin
      r.field_kind = tmbp_pkg::KIND_ERRTEXT;
      if (b != 8'h00) begin
        r.field_byte = b;
        r.byte_valid = 1'b1;
      end else r.message_done = 1'b1;
    end else if (op_reg == tmbp_pkg::OP_FLAGGED && fidx == tmbp_pkg::FI_FIRST) begin
      r.field_kind = tmbp_pkg::KIND_FLAG;
      r.field_byte = b;
      r.byte_valid = 1'b1;
      fidx = tmbp_pkg::FI_SECOND;
    end else if (op_reg == tmbp_pkg::OP_FLAGGED && fidx == tmbp_pkg::FI_SECOND) begin
      r.field_kind = tmbp_pkg::KIND_NAME;
      if (b != 8'h00) begin
        r.field_byte = b;
        r.byte_valid = 1'b1;
      end else r.message_done = 1'b1;
    end else if (op_reg == tmbp_pkg::OP_DATA && fidx == tmbp_pkg::FI_FIRST) begin
      r.field_kind = tmbp_pkg::KIND_SIZE;
      if (collect_pair(b, w)) begin
        size_reg = w;
        r.word_value = w;
        r.word_valid = 1'b1;
        fidx = tmbp_pkg::FI_SECOND;
      end
    end else if (op_reg == tmbp_pkg::OP_DATA && fidx == tmbp_pkg::FI_SECOND) begin
      r.field_kind = tmbp_pkg::KIND_BLOCK;
      if (collect_pair(b, w)) begin
        r.word_value = w;
        r.word_valid = 1'b1;
        if (size_reg == 16'd0) r.message_done = 1'b1;
        else fidx = tmbp_pkg::FI_DATA;
      end
    end else if (op_reg == tmbp_pkg::OP_DATA && fidx == tmbp_pkg::FI_DATA) begin
      r.field_kind = tmbp_pkg::KIND_DATA;
      r.field_byte = b;
      r.byte_valid = 1'b1;
      data_cnt = data_cnt + 1'b1;
      if (data_cnt == size_reg) r.message_done = 1'b1;
    end else begin
      r.field_kind = tmbp_pkg::KIND_NONE;
      r.bad_opcode = 1'b1;
    end
    r.msg_type = op_reg;
    if (r.message_done || r.bad_opcode) clear_parser();
  endfunction

  function automatic void check_field(input string name, input logic [16:0] want,
                                      input logic [16:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result %0d %s mismatch: expected %0h, got %0h",
                 $realtime, results_seen, name, want, got);
    end
  endfunction

  // request and result monitor, watchdog
  always @(posedge clk) begin
    tmbp_pkg::result_t want;
    tmbp_pkg::result_t got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        parse_byte(in_byte, want);
        pending_results.insert(pending_results.size(), want);
      end
      if (out_valid && out_ready) begin
        got = {msg_type, field_kind, field_byte, byte_valid, word_value, word_valid,
               message_done, message_length, bad_opcode};
        results_seen++;
        if (message_done === 1'b1) messages_done++;
        if (bad_opcode === 1'b1) opcodes_rejected++;
        if (int'(message_length) > longest_length) longest_length = message_length;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with no request pending", $realtime);
        end else begin
          want = pending_results.pop_front();
          check_field("msg_type", want.msg_type, got.msg_type);
          check_field("field_kind", want.field_kind, got.field_kind);
          check_field("field_byte", want.field_byte, got.field_byte);
          check_field("byte_valid", want.byte_valid, got.byte_valid);
          check_field("word_value", want.word_value, got.word_value);
          check_field("word_valid", want.word_valid, got.word_valid);
          check_field("message_done", want.message_done, got.message_done);
          check_field("message_length", want.message_length, got.message_length);
          check_field("bad_opcode", want.bad_opcode, got.bad_opcode);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_results.size());
        $display("[tftp_message_byte_parser_unit] ERROR");
        $finish;
      end
    end
  end

  // result receiver
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= !(take_gaps && $urandom_range(0, 99) < 7);
      end
    end
  end

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_byte(input logic [7:0] b);
    while (send_gaps && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  task automatic send_string(input int len);
    int i;
    for (i = 0; i < len; i++) send_byte(8'($urandom_range(1, 255)));
    send_byte(8'h00);
  endtask

  task automatic send_random_message();
    int          pick;
    int          size;
    int          i;
    logic [15:0] op;
    pick = $urandom_range(0, 11);
    if (pick == 11) begin
      for (i = 0; i < $urandom_range(1, 5); i++) send_byte(8'($urandom));
      return;
    end
    if (pick == 10) begin
      do op = 16'($urandom);
      while (op >= tmbp_pkg::OP_RRQ && op <= tmbp_pkg::OP_END_B &&
             $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) op = (op[0]) ? 16'hffff : 16'h0000;
    end else op = 16'(pick + 1);
    send_word(op);
    if ($urandom_range(0, 19) == 0) begin
      // truncated message, the next one starts mid-field
      send_byte(8'($urandom));
      return;
    end
    case (op)
      tmbp_pkg::OP_RRQ, tmbp_pkg::OP_WRQ, tmbp_pkg::OP_NAMED, tmbp_pkg::OP_USER:
        send_string($urandom_range(0, 8));
      tmbp_pkg::OP_ACK: send_word(16'($urandom));
      tmbp_pkg::OP_ERROR: begin
        send_word(16'($urandom));
        send_string($urandom_range(0, 8));
      end
      tmbp_pkg::OP_FLAGGED: begin
        send_byte(8'($urandom));
        send_string($urandom_range(0, 8));
      end
      tmbp_pkg::OP_DATA: begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        send_word(16'(size));
        send_word(16'($urandom));
        for (i = 0; i < size; i++) send_byte(8'($urandom));
      end
      tmbp_pkg::OP_END_A, tmbp_pkg::OP_END_B: ;
      default: send_byte(8'($urandom));
    endcase
  endtask

  task automatic test_short_messages();
    send_word(tmbp_pkg::OP_END_A);
    send_word(tmbp_pkg::OP_END_B);
  endtask

  task automatic test_string_messages();
    send_word(tmbp_pkg::OP_RRQ);
    send_byte(8'hff);
    send_byte(8'h00);
    send_word(tmbp_pkg::OP_WRQ);
    send_byte(8'h00);
    send_word(tmbp_pkg::OP_NAMED);
    send_byte(8'h80);
    send_byte(8'h00);
    send_word(tmbp_pkg::OP_USER);
    send_byte(8'h01);
    send_byte(8'h00);
    send_word(tmbp_pkg::OP_FLAGGED);
    send_byte(8'h00);
    send_byte(8'h7f);
    send_byte(8'h00);
    send_word(tmbp_pkg::OP_ERROR);
    send_word(16'hffff);
    send_byte(8'h41);
    send_byte(8'h00);
  endtask

  task automatic test_word_messages();
    send_word(tmbp_pkg::OP_ACK);
    send_word(16'h0000);
    send_word(tmbp_pkg::OP_DATA);
    send_word(16'h0000);
    send_word(16'hffff);
    send_word(tmbp_pkg::OP_DATA);
    send_word(16'h0002);
    send_word(16'h0001);
    send_byte(8'h00);
    send_byte(8'hff);
  endtask

  task automatic test_unknown_opcodes();
    send_word(16'h0000);
    send_byte(8'h55);
    send_word(16'hffff);
    send_byte(8'haa);
    send_word(16'd11);
    send_byte(8'h00);
    send_word(tmbp_pkg::OP_END_A);
  endtask

  task automatic test_backpressure();
    int i;
    hold_cycles = HOLD_CYCLES;
    for (i = 0; i < 12; i++) send_random_message();
  endtask

  task automatic test_random_traffic();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      // quiet stretch with no idling on either side
      send_gaps = !((bytes_sent - start) > 500 && (bytes_sent - start) < 900);
      take_gaps = send_gaps;
      send_random_message();
    end
    send_gaps = 1'b1;
    take_gaps = 1'b1;
  endtask

  initial begin
    clear_parser();
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_short_messages();
    test_string_messages();
    test_word_messages();
    test_unknown_opcodes();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes, checked %0d results: %0d messages completed, %0d bad opcodes",
             bytes_sent, results_seen, messages_done, opcodes_rejected);
    $display("Every opcode, truncated streams and a long result hold; longest message %0d",
             longest_length);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[tftp_message_byte_parser_unit] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("[tftp_message_byte_parser_unit] ERROR");
    end
    $finish;
  end

endmodule
